@@ rtl/lkvc_pkg.sv @@
// lkvc_pkg: request and response beat types and fixed field widths
// for the lru key-value cache; no dependencies
package lkvc_pkg;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int CAP_BITS = 4;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd2;

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} rsp_t;

endpackage

@@ rtl/lru_key_value_cache_top.sv @@
// lru_key_value_cache_top: fully associative key-value cache with lru replacement
// depends on lkvc_pkg for the beat types and field widths
//
// channel  dir  handshake             beat
// req      in   req_valid/req_ready   req_t: req_type, key, value
// rsp      out  rsp_valid/rsp_ready   rsp_t: hit, read_value, evicted, evicted_key
// cfg      in   cfg_valid/cfg_ready   cfg_data: capacity
//
// one request per cycle while rsp is not stalled; a response passes through
// the input register, then lookup and table update, then the response register
// all keys are compared in parallel and ranks are updated in the same cycle
// arst_n clears valid marks, ranks, fill count, capacity (to 2) and both valids
// a stalled response holds the request register, which then back-pressures req
// cfg_ready is always high
module lru_key_value_cache_top
	import lkvc_pkg::*;
#(
	parameter int ENTRIES  = 8,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  req_t                req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rsp_t                rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_BITS-1:0] cfg_data
);

	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int XW = (CW > CAP_BITS) ? CW : CAP_BITS;

	req_t                req_s1;
	logic                vld_s1;
	rsp_t                rsp_s2;
	logic                vld_s2;
	logic [CAP_BITS-1:0] cap_q;

	logic [KW-1:0]       key_q   [ENTRIES];
	logic [VAL_W-1:0]    value_q [ENTRIES];
	logic [RW-1:0]       rank_q  [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [CW-1:0]       count_q;

	logic                adv;
	logic [KW-1:0]       k;
	logic                is_put;
	logic [ENTRIES-1:0]  hit_vec;
	logic                hit_any;
	logic [RW-1:0]       hit_rank;
	logic [VAL_W-1:0]    hit_val;
	logic                full;
	logic [CW-1:0]       cnt_m1;
	logic [RW-1:0]       last_rank;
	logic [ENTRIES-1:0]  victim_vec;
	logic [KW-1:0]       victim_key;
	logic [ENTRIES-1:0]  valid_left;
	logic [ENTRIES-1:0]  free_vec;
	logic [ENTRIES-1:0]  slot_vec;
	logic                do_ins;
	logic                do_evict;
	logic [RW-1:0]       rank_d  [ENTRIES];
	logic [ENTRIES-1:0]  valid_d;
	logic [CW-1:0]       count_d;
	logic [ENTRIES-1:0]  wr_key;
	logic [ENTRIES-1:0]  wr_val;
	rsp_t                rsp_d;

	assign adv       = vld_s1 && (!vld_s2 || rsp_ready);
	assign req_ready = !vld_s1 || adv;
	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;
	assign cfg_ready = 1'b1;

	assign k      = req_s1.key[KW-1:0];
	assign is_put = (req_s1.req_type == REQ_PUT);

	always_comb begin
		hit_vec    = '0;
		hit_rank   = '0;
		hit_val    = '0;
		victim_vec = '0;
		victim_key = '0;
		full       = ((cap_q == '0) ? (count_q != '0)
			: (XW'(count_q) >= XW'(cap_q))) || (count_q == CW'(ENTRIES));
		cnt_m1     = count_q - CW'(1);
		last_rank  = cnt_m1[RW-1:0];
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == k);
			if (hit_vec[i]) begin
				hit_rank = hit_rank | rank_q[i];
				hit_val  = hit_val | value_q[i];
			end
			victim_vec[i] = full && valid_q[i] && (rank_q[i] == last_rank);
			if (victim_vec[i]) begin
				victim_key = victim_key | key_q[i];
			end
		end
		hit_any    = |hit_vec;
		do_ins     = !hit_any && is_put;
		do_evict   = do_ins && full;
		valid_left = valid_q & ~victim_vec;
		free_vec   = ~valid_left;
		slot_vec   = free_vec & (~free_vec + ENTRIES'(1));
	end

	always_comb begin
		valid_d = valid_q;
		count_d = count_q;
		wr_key  = '0;
		wr_val  = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			rank_d[j] = rank_q[j];
		end
		if (hit_any) begin
			// promote the hit entry, age the more recent ones
			for (int j = 0; j < ENTRIES; j++) begin
				if (hit_vec[j]) begin
					rank_d[j] = '0;
				end else if (valid_q[j] && (rank_q[j] < hit_rank)) begin
					rank_d[j] = rank_q[j] + RW'(1);
				end
			end
			if (is_put) begin
				wr_val = hit_vec;
			end
		end else if (is_put) begin
			// optional eviction, then insert at the lowest free slot
			for (int j = 0; j < ENTRIES; j++) begin
				if (slot_vec[j]) begin
					rank_d[j]  = '0;
					valid_d[j] = 1'b1;
				end else if (valid_left[j]) begin
					rank_d[j] = rank_q[j] + RW'(1);
				end else if (victim_vec[j]) begin
					rank_d[j]  = '0;
					valid_d[j] = 1'b0;
				end
			end
			wr_key  = slot_vec;
			wr_val  = slot_vec;
			count_d = count_q - CW'(do_evict) + CW'(1);
		end
	end

	always_comb begin
		rsp_d.hit         = hit_any;
		rsp_d.read_value  = (hit_any && !is_put) ? hit_val : '0;
		rsp_d.evicted     = do_evict;
		rsp_d.evicted_key = do_evict ? KEY_W'(victim_key) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (rsp_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (adv) begin
			valid_q <= valid_d;
			count_q <= count_d;
			for (int j = 0; j < ENTRIES; j++) begin
				rank_q[j] <= rank_d[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < ENTRIES; j++) begin
			if (adv && wr_key[j]) begin
				key_q[j] <= k;
			end
			if (adv && wr_val[j]) begin
				value_q[j] <= req_s1.value;
			end
		end
	end

endmodule

@@ tb/sv/lru_cache_checker.sv @@
// lru_cache_checker: watches the req, rsp and cfg channels of the lru key-value cache,
// predicts every response from its own copy of the table and compares field by field
// depends on lkvc_pkg for the beat types and field widths
module lru_cache_checker
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  req_t                req,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  rsp_t                rsp,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CAP_BITS-1:0] cfg_data,
	output int                  errors,
	output int                  pending
);

	timeunit 1ns;
	timeprecision 1ps;

	logic             line_valid [ENTRIES];
	logic [KEY_W-1:0] line_key   [ENTRIES];
	logic [VAL_W-1:0] line_val   [ENTRIES];
	int               line_age   [ENTRIES];
	int               fill;
	logic [CAP_BITS-1:0] capacity;

	rsp_t awaited_rsp[$];
	rsp_t want;

	// age 0 is the most recent entry
	function automatic rsp_t lookup_update(input req_t r);
		rsp_t o;
		int found;
		int victim;
		int slot;
		int lim;
		int old_age;
		o = '0;
		found = -1;
		victim = -1;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (found < 0 && line_valid[i] && line_key[i] == r.key)
				found = i;
		end
		if (found >= 0) begin
			o.hit = 1'b1;
			if (r.req_type == REQ_PUT)
				line_val[found] = r.value;
			else
				o.read_value = line_val[found];
			old_age = line_age[found];
			for (int i = 0; i < ENTRIES; i++) begin
				if (line_valid[i] && i != found && line_age[i] < old_age)
					line_age[i]++;
			end
			line_age[found] = 0;
		end else if (r.req_type == REQ_PUT) begin
			lim = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
			if (fill >= lim) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim]))
						victim = i;
				end
				if (victim >= 0) begin
					o.evicted = 1'b1;
					o.evicted_key = line_key[victim];
					line_valid[victim] = 1'b0;
					line_age[victim] = 0;
					fill--;
				end
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot < 0 && !line_valid[i])
					slot = i;
			end
			if (slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (line_valid[i])
						line_age[i]++;
				end
				line_valid[slot] = 1'b1;
				line_key[slot] = r.key;
				line_val[slot] = r.value;
				line_age[slot] = 0;
				fill++;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				line_valid[i] = 1'b0;
				line_key[i] = '0;
				line_val[i] = '0;
				line_age[i] = 0;
			end
			fill = 0;
			capacity = CAP_RESET;
			awaited_rsp.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected rsp beat: expected none, actual %h", $time, rsp);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.hit !== want.hit) begin
						errors++;
						$display("%0t: hit mismatch: expected %0d, actual %0d",
							$time, want.hit, rsp.hit);
					end
					if (rsp.read_value !== want.read_value) begin
						errors++;
						$display("%0t: read_value mismatch: expected %h, actual %h",
							$time, want.read_value, rsp.read_value);
					end
					if (rsp.evicted !== want.evicted) begin
						errors++;
						$display("%0t: evicted mismatch: expected %0d, actual %0d",
							$time, want.evicted, rsp.evicted);
					end
					if (rsp.evicted_key !== want.evicted_key) begin
						errors++;
						$display("%0t: evicted_key mismatch: expected %h, actual %h",
							$time, want.evicted_key, rsp.evicted_key);
					end
				end
			end
			if (req_valid && req_ready)
				awaited_rsp.push_back(lookup_update(req));
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			pending = awaited_rsp.size();
		end
	end

endmodule

@@ tb/sv/lru_key_value_cache_top_test.sv @@
// lru_key_value_cache_top_test: clock, reset and stimulus for the lru key-value cache,
// with lru_cache_checker alongside the block for prediction and comparison
// depends on lkvc_pkg, lru_key_value_cache_top and lru_cache_checker
module lru_key_value_cache_top_test
	import lkvc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_t                req;
	logic                rsp_valid;
	logic                rsp_ready;
	rsp_t                rsp;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_BITS-1:0] cfg_data;

	int   errors;
	int   pending;
	logic quiet;
	logic long_hold;

	logic [KEY_W-1:0] key_pool [12];

	lru_key_value_cache_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lru_cache_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// rsp side: random stall bursts plus one long hold-off on request
	initial begin
		int stall;
		rsp_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_ready <= 1'b0;
				repeat (60) @(negedge clk);
				long_hold = 1'b0;
				rsp_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 9);
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	function automatic req_t cache_req(input logic kind, input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v);
		req_t r;
		r.req_type = kind;
		r.key = k;
		r.value = v;
		return r;
	endfunction

	task automatic issue(input req_t r);
		int gap;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		req_t r;
		int   cap_setting;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 12; i++)
			key_pool[i] = $urandom;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset capacity of two: miss, fill, hit, eviction, update in place
		issue(cache_req(REQ_GET, 32'h0000_0000, 32'hffff_ffff));
		issue(cache_req(REQ_PUT, 32'h0000_0000, 32'hffff_ffff));
		issue(cache_req(REQ_PUT, 32'hffff_ffff, 32'h0000_0000));
		issue(cache_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));
		issue(cache_req(REQ_PUT, 32'h0000_0005, 32'h0000_1234));
		issue(cache_req(REQ_PUT, 32'h0000_0000, 32'ha5a5_a5a5));
		issue(cache_req(REQ_GET, 32'hffff_ffff, 32'h0000_0000));
		issue(cache_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));
		drain();

		// capacity above the table size acts as full size
		write_capacity(4'd15);
		for (int i = 0; i < 9; i++)
			issue(cache_req(REQ_PUT, 32'd100 + i, $urandom));
		drain();

		// capacity zero acts as one, lowered below the fill
		write_capacity(4'd0);
		issue(cache_req(REQ_PUT, 32'd200, 32'h5a5a_5a5a));
		issue(cache_req(REQ_GET, 32'd108, 32'h0000_0000));
		issue(cache_req(REQ_PUT, 32'd201, 32'h0000_0001));
		issue(cache_req(REQ_GET, 32'd200, 32'h0000_0000));
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: cap_setting = 1;
				1: cap_setting = 8;
				2: cap_setting = 15;
				3: cap_setting = 0;
				4: cap_setting = 2;
				default: cap_setting = $urandom_range(0, 15);
			endcase
			write_capacity(cap_setting[CAP_BITS-1:0]);
			quiet = (phase == 9);
			for (int n = 0; n < 180; n++) begin
				if (phase == 4 && n == 60)
					long_hold = 1'b1;
				if (phase == 5 && n == 90)
					drain();
				r.req_type = 1'($urandom_range(0, 1));
				r.key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 11)] : $urandom;
				r.value = $urandom;
				issue(r);
			end
			drain();
		end

		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
